/* rtl/nis_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nis_pkg
// Shared types and constants for the Newton integer square root core.
// ----------------------------------------------------------------------------
package nis_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROOT_W = 16;

  localparam logic [WORD_W-1:0] SEED_LIMIT_LOW   = 32'd4194304;
  localparam logic [WORD_W-1:0] SEED_LIMIT_MID   = 32'd134217728;
  localparam logic [WORD_W-1:0] SEED_OFFSET_LOW  = 32'd63;
  localparam logic [WORD_W-1:0] SEED_OFFSET_MID  = 32'd255;
  localparam logic [WORD_W-1:0] SEED_OFFSET_HIGH = 32'd1023;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] number;
    logic [WORD_W-1:0] guess;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dend;
    logic [WORD_W-1:0] quot;
  } nis_lane_t;

endpackage
`default_nettype wire

/* rtl/nis_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nis_in_if / nis_out_if
// Valid/ready channels carrying the number and the root.
// ----------------------------------------------------------------------------
interface nis_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] number;
  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface nis_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] root;
  modport source (output valid, output root, input ready);
  modport sink (input valid, input root, output ready);
endinterface
`default_nettype wire

/* rtl/nis_seed.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nis_seed
// Pick the range seed and load the first division cell lane.
// ----------------------------------------------------------------------------
module nis_seed
  import nis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [WORD_W-1:0] in_number,
  output nis_lane_t              lane_o
);

  nis_lane_t lane_r;
  nis_lane_t lane_nxt;

  always_comb begin
    lane_nxt        = '0;
    lane_nxt.valid  = in_valid;
    lane_nxt.number = in_number;
    lane_nxt.dend   = in_number;
    if (in_number == '0) begin
      lane_nxt.guess = '0;
    end else if (in_number <= SEED_LIMIT_LOW) begin
      lane_nxt.guess = (in_number >> 10) + SEED_OFFSET_LOW;
    end else if (in_number <= SEED_LIMIT_MID) begin
      lane_nxt.guess = (in_number >> 12) + SEED_OFFSET_MID;
    end else begin
      lane_nxt.guess = (in_number >> 14) + SEED_OFFSET_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.number <= lane_nxt.number;
      lane_r.guess  <= lane_nxt.guess;
      lane_r.rem    <= lane_nxt.rem;
      lane_r.dend   <= lane_nxt.dend;
      lane_r.quot   <= lane_nxt.quot;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

/* rtl/nis_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nis_div_cell
// One restoring division step: one quotient bit of number / guess.
// ----------------------------------------------------------------------------
module nis_div_cell
  import nis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire nis_lane_t lane_i,
  output nis_lane_t      lane_o
);

  nis_lane_t       lane_r;
  nis_lane_t       lane_nxt;
  logic [WORD_W:0] trial;
  logic [WORD_W:0] diff;

  always_comb begin
    trial    = {lane_i.rem, lane_i.dend[WORD_W-1]};
    diff     = trial - {1'b0, lane_i.guess};
    lane_nxt = lane_i;
    lane_nxt.dend = {lane_i.dend[WORD_W-2:0], 1'b0};
    if (!diff[WORD_W]) begin
      lane_nxt.rem  = diff[WORD_W-1:0];
      lane_nxt.quot = {lane_i.quot[WORD_W-2:0], 1'b1};
    end else begin
      lane_nxt.rem  = trial[WORD_W-1:0];
      lane_nxt.quot = {lane_i.quot[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.number <= lane_nxt.number;
      lane_r.guess  <= lane_nxt.guess;
      lane_r.rem    <= lane_nxt.rem;
      lane_r.dend   <= lane_nxt.dend;
      lane_r.quot   <= lane_nxt.quot;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

/* rtl/nis_update_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nis_update_cell
// Close one Newton step: guess becomes (guess + quotient) / 2.
// ----------------------------------------------------------------------------
module nis_update_cell
  import nis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire nis_lane_t lane_i,
  output nis_lane_t      lane_o
);

  nis_lane_t         lane_r;
  nis_lane_t         lane_nxt;
  logic [WORD_W-1:0] sum;

  always_comb begin
    sum             = lane_i.guess + lane_i.quot;
    lane_nxt        = '0;
    lane_nxt.valid  = lane_i.valid;
    lane_nxt.number = lane_i.number;
    lane_nxt.dend   = lane_i.number;
    // hold a zero guess at zero
    lane_nxt.guess  = (lane_i.guess == '0) ? '0 : (sum >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.number <= lane_nxt.number;
      lane_r.guess  <= lane_nxt.guess;
      lane_r.rem    <= lane_nxt.rem;
      lane_r.dend   <= lane_nxt.dend;
      lane_r.quot   <= lane_nxt.quot;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

/* rtl/newton_integer_sqrt_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// newton_integer_sqrt_core
// Approximate 16-bit square root of a 32-bit number by seeded Newton steps.
// ----------------------------------------------------------------------------
// Fully pipelined: one item enters per cycle unless the output item is
// held. A seed stage picks the range seed, then each Newton step is a
// row of 32 restoring division cells (one quotient bit per cell) followed
// by one update cell that averages guess and quotient. The whole pipeline
// stalls while the output item is held.
module newton_integer_sqrt_core
  import nis_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = 5
)
(
  input wire logic  clk,
  input wire logic  rst_n,
  nis_in_if.sink    in_if,
  nis_out_if.source out_if
);

  localparam int unsigned CELLS_PER_STEP = WORD_W + 1;
  localparam int unsigned LANES          = NEWTON_STEPS * CELLS_PER_STEP + 1;

  nis_lane_t lane [LANES];
  logic      en;

  assign en           = !lane[LANES-1].valid || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = lane[LANES-1].valid;
  assign out_if.root  = lane[LANES-1].guess[ROOT_W-1:0];

  nis_seed u_seed (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_if.valid),
    .in_number(in_if.number),
    .lane_o   (lane[0])
  );

  for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
    for (genvar b = 0; b < WORD_W; b++) begin : g_div
      nis_div_cell u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .lane_i(lane[s*CELLS_PER_STEP + b]),
        .lane_o(lane[s*CELLS_PER_STEP + b + 1])
      );
    end
    nis_update_cell u_upd (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .lane_i(lane[s*CELLS_PER_STEP + WORD_W]),
      .lane_o(lane[(s+1)*CELLS_PER_STEP])
    );
  end

endmodule
`default_nettype wire
